// ===== design/spherigon_point_smoothing_core_defines.svh =====
// assertion macros for the spherigon point smoothing core
`ifndef SPHERIGON_POINT_SMOOTHING_CORE_DEFINES_SVH
`define SPHERIGON_POINT_SMOOTHING_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spr assertion failed");

// next-cycle implication, checked out of reset
`define SPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spr assertion failed");

`endif

// ===== design/spr_pkg.sv =====
// shared types, constants and helpers of the spherigon point smoothing core
`default_nettype none
package spr_pkg;

    localparam int SPR_VERTEX_COUNT = 4096;
    localparam int SPR_WBITS        = 17;
    localparam int SPR_POS_W        = 24;
    localparam int SPR_NRM_W        = 16;
    localparam int SPR_WORD_W       = 3 * SPR_POS_W + 3 * SPR_NRM_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } alu_rsp_t;

    typedef struct packed {
        logic               cmd;
        logic [11:0]        vertex_index;
        logic signed [23:0] load_pos_x;
        logic signed [23:0] load_pos_y;
        logic signed [23:0] load_pos_z;
        logic signed [15:0] load_nrm_x;
        logic signed [15:0] load_nrm_y;
        logic signed [15:0] load_nrm_z;
        logic [11:0]        corner_a;
        logic [11:0]        corner_b;
        logic [11:0]        corner_c;
        logic [50:0]        weights;
    } spr_in_t;

    typedef struct packed {
        logic signed [23:0] out_pos_x;
        logic signed [23:0] out_pos_y;
        logic signed [23:0] out_pos_z;
        logic signed [15:0] out_nrm_x;
        logic signed [15:0] out_nrm_y;
        logic signed [15:0] out_nrm_z;
        logic               degenerate;
    } spr_out_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // shift right by k, rounding half away from zero
    function automatic logic [63:0] rshr64(input logic [63:0] v, input int unsigned k);
        logic [63:0] q;
        q = (mag64(v) + (64'd1 << (k - 1))) >> k;
        return v[63] ? (~q + 64'd1) : q;
    endfunction

endpackage
`default_nettype wire

// ===== design/spherigon_point_smoothing_core.sv =====
// spherigon point smoothing core: vertex store, step sequencer and datapath
// a load item leaves busy low; the vertex is written at the accept edge
// an evaluate item runs as a sequence of jobs on the shared iterative unit:
// 78 multiplies, 9 divides and one square root
// one item at a time; the single strobed result comes in the first cycle with busy low
// reset clears the sequencer and the result strobe; the vertex store is not cleared
`default_nettype none
`include "spherigon_point_smoothing_core_defines.svh"
module spherigon_point_smoothing_core
    import spr_pkg::*;
#(
    parameter int VERTEX_COUNT = SPR_VERTEX_COUNT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire spr_in_t item,
    output logic         busy,
    output logic         result_valid,
    output spr_out_t     result
);

    localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_CAP, S_NR, S_PQ, S_SUM, S_CHK, S_NORM, S_SHIFT,
        S_LEN, S_SQRT, S_U, S_R, S_DOT, S_H, S_K, S_NUM, S_DD, S_DEN,
        S_LIFT, S_LU, S_ACC, S_OUT, S_DEG
    } state_t;

    // sequencer state
    state_t     state_reg, state_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] c_reg, c_next;
    logic       issued_reg, issued_next;
    logic       valid_reg, valid_next;
    spr_out_t   result_reg, result_next;

    alu_req_t   alu_req;
    alu_rsp_t   alu_rsp;

    // item registers
    logic [11:0]        corner_reg [3];
    logic [16:0]        w_reg [3];
    logic signed [23:0] p_reg [3][3];
    logic signed [15:0] n_reg [3][3];

    // working registers, 64-bit two's complement but for the 6-bit shift count
    logic [63:0] nr_reg [3];
    logic [63:0] pq_reg [3];
    logic [63:0] ww_reg [3];
    logic [63:0] u_reg [3];
    logic [63:0] pc_reg [3];
    logic [63:0] r_reg [3];
    logic [63:0] k_reg [3];
    logic [63:0] acc_reg [3];
    logic [63:0] sum_reg;
    logic [63:0] len2_reg;
    logic [63:0] root_reg;
    logic [63:0] maxabs_reg;
    logic [5:0]  shift_reg;
    logic [63:0] dot_reg;
    logic [63:0] h_reg;
    logic [63:0] num_reg;
    logic [63:0] dd_reg;
    logic [63:0] den_reg;
    // saturated lift, held while it is multiplied into each lane
    logic [63:0] lift_sat_hold;

    // vertex store
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [SPR_WORD_W-1:0] ram_wdata;
    logic [SPR_WORD_W-1:0] ram_rdata;

    logic        accept;
    logic        corner_ok;
    logic [63:0] pi_cur;
    logic [63:0] n_cur;
    logic [63:0] den_cur;
    logic [63:0] num_sh;
    logic [63:0] lift_mag;
    logic [63:0] lift_raw;
    logic [63:0] lift_sat;
    logic        mul_last9;
    logic [63:0] q_pos [3];
    logic [63:0] q_nrm [3];
    logic [23:0] pos_sat [3];

    function automatic logic [63:0] se24(input logic [23:0] v);
        return {{40{v[23]}}, v};
    endfunction

    function automatic logic [63:0] se16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [23:0] sat24(input logic [63:0] v);
        if (!v[63] && (v > 64'd8388607))
        begin
            return 24'h7FFFFF;
        end
        else if (v[63] && (v < 64'hFFFF_FFFF_FF80_0000))
        begin
            return 24'h800000;
        end
        return v[23:0];
    endfunction

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    assign ram_we    = accept && (item.cmd == CMD_LOAD) &&
                       (32'(item.vertex_index) < VERTEX_COUNT);
    assign ram_waddr = ADDR_W'(item.vertex_index);
    assign ram_wdata = {item.load_nrm_z, item.load_nrm_y, item.load_nrm_x,
                        item.load_pos_z, item.load_pos_y, item.load_pos_x};
    assign ram_raddr = ADDR_W'(corner_reg[j_reg]);
    assign corner_ok = (32'(corner_reg[j_reg]) < VERTEX_COUNT);

    spr_ram #(
        .WIDTH (SPR_WORD_W),
        .DEPTH (VERTEX_COUNT),
        .ADDR_W(ADDR_W)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    spr_alu u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (alu_req),
        .rsp  (alu_rsp)
    );

    // corner position in q.20 and corner normal of the current lane
    assign pi_cur = se24(p_reg[j_reg][c_reg]) << 4;
    assign n_cur  = se16(n_reg[j_reg][c_reg]);

    // denominator 1 + u.ni in q.24
    assign den_cur = rshr64(dd_reg, 20) + (64'd1 << 24);

    // lift = round(num * 2^10 / den), saturated to 2^32
    assign num_sh   = num_reg << 10;
    assign lift_mag = alu_rsp.res;
    assign lift_raw = (num_sh[63] != den_reg[63]) ? (~lift_mag + 64'd1) : lift_mag;
    always_comb
    begin
        lift_sat = lift_raw;
        if (!lift_raw[63] && (lift_raw > (64'd1 << 32)))
        begin
            lift_sat = 64'd1 << 32;
        end
        else if (lift_raw[63] && (mag64(lift_raw) > (64'd1 << 32)))
        begin
            lift_sat = ~(64'd1 << 32) + 64'd1;
        end
    end

    // final rounding of position and normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_pos[i]   = rshr64(acc_reg[i], 32);
            q_nrm[i]   = rshr64(u_reg[i], 16);
            pos_sat[i] = sat24(q_pos[i]);
        end
    end

    assign mul_last9 = (j_reg == 2'd2) && (c_reg == 2'd2);

    // sequencer: each arithmetic step issues one job to the shared unit and
    // advances its lane counter when the unit reports done
    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        c_next      = c_reg;
        issued_next = issued_reg;
        valid_next  = 1'b0;
        result_next = result_reg;
        alu_req     = '0;
        alu_req.op  = ALU_MUL;

        // operand select for the shared unit
        unique case (state_reg)
            S_NR:
            begin
                alu_req.a = 64'(w_reg[j_reg]);
                alu_req.b = n_cur;
            end
            S_PQ:
            begin
                alu_req.a = 64'(w_reg[j_reg]);
                alu_req.b = se24(p_reg[j_reg][c_reg]);
            end
            S_SUM:
            begin
                alu_req.a = 64'(w_reg[j_reg]);
                alu_req.b = 64'(w_reg[j_reg]);
            end
            S_LEN:
            begin
                alu_req.a = nr_reg[c_reg];
                alu_req.b = nr_reg[c_reg];
            end
            S_SQRT:
            begin
                alu_req.op = ALU_SQRT;
                alu_req.a  = len2_reg;
            end
            S_U:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = (mag64(nr_reg[c_reg]) << 30) + (root_reg >> 1);
                alu_req.b  = root_reg;
            end
            S_R:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = (ww_reg[j_reg] << 28) + (sum_reg >> 1);
                alu_req.b  = sum_reg;
            end
            S_DOT:
            begin
                alu_req.a = pi_cur - pc_reg[c_reg];
                alu_req.b = u_reg[c_reg];
            end
            S_K:
            begin
                alu_req.a = h_reg;
                alu_req.b = u_reg[c_reg];
            end
            S_NUM:
            begin
                alu_req.a = pi_cur - k_reg[c_reg];
                alu_req.b = n_cur;
            end
            S_DD:
            begin
                alu_req.a = u_reg[c_reg];
                alu_req.b = n_cur;
            end
            S_LIFT:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = mag64(num_sh) + (mag64(den_reg) >> 1);
                alu_req.b  = mag64(den_reg);
            end
            S_LU:
            begin
                alu_req.a = lift_sat_hold;
                alu_req.b = u_reg[c_reg];
            end
            S_ACC:
            begin
                alu_req.a = r_reg[j_reg];
                alu_req.b = k_reg[c_reg];
            end
            default:
            begin
                alu_req.a = '0;
                alu_req.b = '0;
            end
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.cmd == CMD_EVAL))
                begin
                    j_next     = 2'd0;
                    c_next     = 2'd0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                if (j_reg == 2'd2)
                begin
                    j_next     = 2'd0;
                    state_next = S_NR;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_CHK:
            begin
                if ((sum_reg == 64'd0) ||
                    ((nr_reg[0] == 64'd0) && (nr_reg[1] == 64'd0) && (nr_reg[2] == 64'd0)))
                begin
                    state_next = S_DEG;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (maxabs_reg < (64'd1 << 31))
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                c_next     = 2'd0;
                state_next = S_LEN;
            end
            S_H:
            begin
                c_next     = 2'd0;
                state_next = S_K;
            end
            S_DEN:
            begin
                state_next = (den_cur == 64'd0) ? S_DEG : S_LIFT;
            end
            S_OUT:
            begin
                result_next.out_pos_x  = pos_sat[0];
                result_next.out_pos_y  = pos_sat[1];
                result_next.out_pos_z  = pos_sat[2];
                result_next.out_nrm_x  = q_nrm[0][15:0];
                result_next.out_nrm_y  = q_nrm[1][15:0];
                result_next.out_nrm_z  = q_nrm[2][15:0];
                result_next.degenerate = 1'b0;
                valid_next             = 1'b1;
                state_next             = S_IDLE;
            end
            S_DEG:
            begin
                result_next            = '0;
                result_next.degenerate = 1'b1;
                valid_next             = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                // every remaining state is one job on the shared unit
                if (!issued_reg)
                begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (alu_rsp.done)
                begin
                    issued_next = 1'b0;
                    unique case (state_reg)
                        S_NR, S_PQ:
                        begin
                            // nine products, lane c inner, corner j outer
                            if (c_reg == 2'd2)
                            begin
                                c_next = 2'd0;
                                j_next = j_reg + 2'd1;
                            end
                            else
                            begin
                                c_next = c_reg + 2'd1;
                            end
                            if (mul_last9)
                            begin
                                j_next     = 2'd0;
                                state_next = (state_reg == S_NR) ? S_PQ : S_SUM;
                            end
                        end
                        S_SUM:
                        begin
                            j_next = j_reg + 2'd1;
                            if (j_reg == 2'd2)
                            begin
                                j_next     = 2'd0;
                                state_next = S_CHK;
                            end
                        end
                        S_R:
                        begin
                            j_next = j_reg + 2'd1;
                            if (j_reg == 2'd2)
                            begin
                                j_next     = 2'd0;
                                c_next     = 2'd0;
                                state_next = S_DOT;
                            end
                        end
                        S_SQRT:
                        begin
                            c_next     = 2'd0;
                            state_next = S_U;
                        end
                        S_LIFT:
                        begin
                            c_next     = 2'd0;
                            state_next = S_LU;
                        end
                        default:
                        begin
                            // three-lane steps
                            c_next = c_reg + 2'd1;
                            if (c_reg == 2'd2)
                            begin
                                c_next = 2'd0;
                                case (state_reg)
                                    S_LEN:   state_next = S_SQRT;
                                    S_U:     state_next = S_R;
                                    S_DOT:   state_next = S_H;
                                    S_K:     state_next = S_NUM;
                                    S_NUM:   state_next = S_DD;
                                    S_DD:    state_next = S_DEN;
                                    S_LU:    state_next = S_ACC;
                                    default:
                                    begin
                                        if (j_reg == 2'd2)
                                        begin
                                            state_next = S_OUT;
                                        end
                                        else
                                        begin
                                            j_next     = j_reg + 2'd1;
                                            state_next = S_DOT;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            j_reg      <= 2'd0;
            c_reg      <= 2'd0;
            issued_reg <= 1'b0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            j_reg      <= j_next;
            c_reg      <= c_next;
            issued_reg <= issued_next;
            valid_reg  <= valid_next;
            result_reg <= result_next;
        end
    end

    // datapath registers, written by the step that owns them
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                corner_reg[0] <= item.corner_a;
                corner_reg[1] <= item.corner_b;
                corner_reg[2] <= item.corner_c;
                for (int i = 0; i < 3; i++)
                begin
                    w_reg[i]   <= item.weights[i*SPR_WBITS +: SPR_WBITS];
                    nr_reg[i]  <= '0;
                    pq_reg[i]  <= '0;
                    acc_reg[i] <= '0;
                end
                sum_reg   <= '0;
                len2_reg  <= '0;
                shift_reg <= '0;
                dot_reg   <= '0;
            end
            S_CAP:
            begin
                // a corner beyond the store reads as zero
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[j_reg][i] <= corner_ok ?
                        ram_rdata[i*SPR_POS_W +: SPR_POS_W] : '0;
                    n_reg[j_reg][i] <= corner_ok ?
                        ram_rdata[3*SPR_POS_W + i*SPR_NRM_W +: SPR_NRM_W] : '0;
                end
            end
            S_CHK:
            begin
                if (mag64(nr_reg[1]) > mag64(nr_reg[0]) &&
                    mag64(nr_reg[1]) >= mag64(nr_reg[2]))
                begin
                    maxabs_reg <= mag64(nr_reg[1]);
                end
                else if (mag64(nr_reg[2]) > mag64(nr_reg[0]) &&
                         mag64(nr_reg[2]) > mag64(nr_reg[1]))
                begin
                    maxabs_reg <= mag64(nr_reg[2]);
                end
                else
                begin
                    maxabs_reg <= mag64(nr_reg[0]);
                end
            end
            S_NORM:
            begin
                if (maxabs_reg >= (64'd1 << 31))
                begin
                    maxabs_reg <= maxabs_reg >> 1;
                    shift_reg  <= shift_reg + 6'd1;
                end
            end
            S_SHIFT:
            begin
                // bring the normal sum below 2^31, truncating magnitudes; center point in q.20
                for (int i = 0; i < 3; i++)
                begin
                    nr_reg[i] <= nr_reg[i][63] ?
                        (~(mag64(nr_reg[i]) >> shift_reg) + 64'd1) :
                        (mag64(nr_reg[i]) >> shift_reg);
                    pc_reg[i] <= rshr64(pq_reg[i], 12);
                end
            end
            S_H:
            begin
                h_reg   <= rshr64(dot_reg, 30);
                dot_reg <= '0;
                num_reg <= '0;
                dd_reg  <= '0;
            end
            S_DEN:
            begin
                den_reg <= den_cur;
            end
            default:
            begin
                if (alu_rsp.done && issued_reg)
                begin
                    case (state_reg)
                        S_NR:   nr_reg[c_reg] <= nr_reg[c_reg] + alu_rsp.res;
                        S_PQ:   pq_reg[c_reg] <= pq_reg[c_reg] + alu_rsp.res;
                        S_SUM:
                        begin
                            sum_reg       <= sum_reg + alu_rsp.res;
                            ww_reg[j_reg] <= alu_rsp.res;
                        end
                        S_LEN:  len2_reg <= len2_reg + alu_rsp.res;
                        S_SQRT: root_reg <= alu_rsp.res;
                        S_U:    u_reg[c_reg] <= nr_reg[c_reg][63] ?
                                    (~alu_rsp.res + 64'd1) : alu_rsp.res;
                        S_R:    r_reg[j_reg] <= alu_rsp.res;
                        S_DOT:  dot_reg <= dot_reg + alu_rsp.res;
                        S_K:    k_reg[c_reg] <= pc_reg[c_reg] + rshr64(alu_rsp.res, 30);
                        S_NUM:  num_reg <= num_reg + alu_rsp.res;
                        S_DD:   dd_reg <= dd_reg + alu_rsp.res;
                        S_LIFT: lift_sat_hold <= lift_sat;
                        S_LU:   k_reg[c_reg] <= k_reg[c_reg] + rshr64(alu_rsp.res, 30);
                        S_ACC:  acc_reg[c_reg] <= acc_reg[c_reg] + alu_rsp.res;
                        default:
                        begin
                            dd_reg <= dd_reg;
                        end
                    endcase
                end
            end
        endcase
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    // one strobe per evaluate item, and the sequencer is back in idle by then
    `SPR_ASSERT_NXT(a_single_strobe, result_valid, !result_valid)
    `SPR_ASSERT_IMP(a_strobe_idle, result_valid, !busy)
    // an accepted evaluate item always occupies the sequencer
    `SPR_ASSERT_NXT(a_eval_busy, start && !busy && (item.cmd == CMD_EVAL), busy)
    // a degenerate result carries zero fields; out_pos_x and out_nrm_z are checked
    `SPR_ASSERT_IMP(a_degenerate_zero, result_valid && result.degenerate,
        (result.out_pos_x == 24'sd0) && (result.out_nrm_z == 16'sd0))

endmodule
`default_nettype wire

// ===== design/spr_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/spr_alu.sv =====
// shared iterative unit: shift-add multiply, restoring divide, integer square root
`default_nettype none
module spr_alu
    import spr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    typedef enum logic {A_IDLE, A_RUN} astate_t;

    astate_t     state_reg, state_next;
    alu_op_t     op_reg, op_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [64:0] z_reg, z_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [63:0] res_reg, res_next;

    logic [64:0] rem_sh;
    logic [64:0] root_try;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rem_sh     = {z_reg[63:0], x_reg[63]};
        root_try   = z_reg + {1'b0, y_reg};
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    x_next     = req.a;
                    y_next     = (req.op == ALU_SQRT) ? (64'd1 << 62) : req.b;
                    z_next     = '0;
                    cnt_next   = '0;
                    state_next = A_RUN;
                end
            end
            A_RUN:
            begin
                unique case (op_reg)
                    ALU_MUL:
                    begin
                        if (y_reg == 64'd0)
                        begin
                            res_next   = z_reg[63:0];
                            done_next  = 1'b1;
                            state_next = A_IDLE;
                        end
                        else
                        begin
                            if (y_reg[0])
                            begin
                                z_next = {1'b0, z_reg[63:0] + x_reg};
                            end
                            x_next = x_reg << 1;
                            y_next = y_reg >> 1;
                        end
                    end
                    ALU_DIV:
                    begin
                        if (rem_sh >= {1'b0, y_reg})
                        begin
                            z_next = rem_sh - {1'b0, y_reg};
                            x_next = {x_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            z_next = rem_sh;
                            x_next = {x_reg[62:0], 1'b0};
                        end
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_reg == 6'd63)
                        begin
                            res_next   = x_next;
                            done_next  = 1'b1;
                            state_next = A_IDLE;
                        end
                    end
                    ALU_SQRT:
                    begin
                        if ({1'b0, x_reg} >= root_try)
                        begin
                            x_next = x_reg - root_try[63:0];
                            z_next = (z_reg >> 1) + {1'b0, y_reg};
                        end
                        else
                        begin
                            z_next = z_reg >> 1;
                        end
                        y_next   = y_reg >> 2;
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_reg == 6'd31)
                        begin
                            res_next   = z_next[63:0];
                            done_next  = 1'b1;
                            state_next = A_IDLE;
                        end
                    end
                    default:
                    begin
                        res_next   = '0;
                        done_next  = 1'b1;
                        state_next = A_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            op_reg    <= ALU_MUL;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule
`default_nettype wire

// ===== tb/spherigon_point_smoothing_core_tb.sv =====
// self-checking testbench of the spherigon point smoothing core: directed rows, then random items
`default_nettype none
module spherigon_point_smoothing_core_tb
    import spr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ITEM_TARGET = 1050;
    localparam longint CYCLE_LIMIT = 30_000_000;
    localparam logic signed [15:0] UNIT = 16'sd16384;

    logic     clk;
    logic     rst_n;
    logic     start;
    spr_in_t  item;
    logic     busy;
    logic     result_valid;
    spr_out_t result;

    spherigon_point_smoothing_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // directed row: typed expectation where it is obvious, predictor otherwise
    typedef struct {
        spr_in_t  stim;
        bit       typed;
        spr_out_t point;
    } row_t;

    // own copy of the vertex store
    longint   vx_pos[4096][3];
    longint   vx_nrm[4096][3];
    bit       vx_written[4096];
    int       written_list[$];

    spr_out_t pending_points[$];
    row_t     rows[$];
    int       errors = 0;
    longint   cycles = 0;
    int       items_sent = 0;
    int       burst_left = 0;

    // clock, 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on total cycles
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // predictor arithmetic, 64-bit two's complement as in the spec
    // ---------------------------------------------------------------------
    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? (64'd0 - longint'(v)) : longint'(v);
    endfunction

    // divide, rounding half away from zero
    function automatic longint round_div(input longint n, input longint d);
        longint unsigned an, ad, q;
        an = magnitude(n);
        ad = magnitude(d);
        q  = (an + ad / 2) / ad;
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // right shift, rounding half away from zero
    function automatic longint round_shift(input longint v, input int k);
        longint unsigned q;
        q = (magnitude(v) + (64'd1 << (k - 1))) >> k;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // floor integer square root
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // smoothed point and unit normal of one evaluate item
    function automatic spr_out_t smooth_point(input spr_in_t it);
        spr_out_t o;
        longint p[3][3], n[3][3], w[3], nr[3], pq[3], u[3], pc[3], acc[3];
        longint pi_v[3], kp[3], dot, num, dd, h, den, lift, m, q, nq;
        longint unsigned r[3], wsum, maxabs, len2, len, mm;
        int k, idx[3];
        logic signed [23:0] opos[3];
        logic signed [15:0] onrm[3];
        o      = '0;
        wsum   = 0;
        maxabs = 0;
        len2   = 0;
        k      = 0;
        idx[0] = it.corner_a;
        idx[1] = it.corner_b;
        idx[2] = it.corner_c;
        for (int j = 0; j < 3; j++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p[j][c] = vx_pos[idx[j]][c];
                n[j][c] = vx_nrm[idx[j]][c];
            end
            w[j] = longint'(it.weights[SPR_WBITS*j +: SPR_WBITS]);
        end
        for (int c = 0; c < 3; c++)
        begin
            nr[c] = 0;
            pq[c] = 0;
            for (int j = 0; j < 3; j++)
            begin
                nr[c] += w[j] * n[j][c];
                pq[c] += w[j] * p[j][c];
            end
            if (magnitude(nr[c]) > maxabs) maxabs = magnitude(nr[c]);
        end
        for (int j = 0; j < 3; j++) wsum += longint'(w[j] * w[j]);
        // zero weight sum or zero normal
        if (wsum == 0 || maxabs == 0)
        begin
            o.degenerate = 1'b1;
            return o;
        end
        while ((maxabs >> k) >= (64'd1 << 31)) k++;
        for (int c = 0; c < 3; c++)
        begin
            mm   = magnitude(nr[c]) >> k;
            len2 += mm * mm;
        end
        len = floor_sqrt(len2);
        for (int c = 0; c < 3; c++)
        begin
            m = longint'(magnitude(nr[c]) >> k);
            if (nr[c] < 0) m = -m;
            u[c]   = round_div(m * 64'sd1073741824, longint'(len));
            pc[c]  = round_shift(pq[c], 12);
            acc[c] = 0;
        end
        for (int j = 0; j < 3; j++)
            r[j] = ((longint'(w[j] * w[j]) << 28) + wsum / 2) / wsum;
        for (int j = 0; j < 3; j++)
        begin
            dot = 0;
            num = 0;
            dd  = 0;
            for (int c = 0; c < 3; c++)
            begin
                pi_v[c] = p[j][c] * 16;
                dot += (pi_v[c] - pc[c]) * u[c];
            end
            h = round_shift(dot, 30);
            for (int c = 0; c < 3; c++)
            begin
                kp[c] = pc[c] + round_shift(h * u[c], 30);
                num += (pi_v[c] - kp[c]) * n[j][c];
                dd  += u[c] * n[j][c];
            end
            den = round_shift(dd, 20) + (64'sd1 << 24);
            // corner facing away: denominator vanishes
            if (den == 0)
            begin
                o = '0;
                o.degenerate = 1'b1;
                return o;
            end
            lift = round_div(num * 1024, den);
            if (lift > (64'sd1 << 32)) lift = 64'sd1 << 32;
            if (lift < -(64'sd1 << 32)) lift = -(64'sd1 << 32);
            for (int c = 0; c < 3; c++)
                acc[c] += longint'(r[j]) * (kp[c] + round_shift(lift * u[c], 30));
        end
        for (int c = 0; c < 3; c++)
        begin
            q = round_shift(acc[c], 32);
            if (q > 8388607) q = 8388607;
            if (q < -8388608) q = -8388608;
            opos[c] = q[23:0];
            nq      = round_shift(u[c], 16);
            onrm[c] = nq[15:0];
        end
        o.out_pos_x  = opos[0];
        o.out_pos_y  = opos[1];
        o.out_pos_z  = opos[2];
        o.out_nrm_x  = onrm[0];
        o.out_nrm_y  = onrm[1];
        o.out_nrm_z  = onrm[2];
        o.degenerate = 1'b0;
        return o;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus construction
    // ---------------------------------------------------------------------
    // random background so unused fields toggle too
    function automatic spr_in_t noise_item();
        logic [223:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return spr_in_t'(bits[$bits(spr_in_t)-1:0]);
    endfunction

    function automatic spr_in_t load_item(input int idx, input int px, input int py,
                                          input int pz, input int nx, input int ny,
                                          input int nz);
        spr_in_t it;
        it              = noise_item();
        it.cmd          = CMD_LOAD;
        it.vertex_index = idx[11:0];
        it.load_pos_x   = px[23:0];
        it.load_pos_y   = py[23:0];
        it.load_pos_z   = pz[23:0];
        it.load_nrm_x   = nx[15:0];
        it.load_nrm_y   = ny[15:0];
        it.load_nrm_z   = nz[15:0];
        return it;
    endfunction

    function automatic spr_in_t eval_item(input int a, input int b, input int c,
                                          input int w0, input int w1, input int w2);
        spr_in_t it;
        it          = noise_item();
        it.cmd      = CMD_EVAL;
        it.corner_a = a[11:0];
        it.corner_b = b[11:0];
        it.corner_c = c[11:0];
        it.weights  = {w2[16:0], w1[16:0], w0[16:0]};
        return it;
    endfunction

    function automatic void add_row(input spr_in_t it, input bit typed, input bit degen);
        row_t rw;
        rw.stim             = it;
        rw.typed            = typed;
        rw.point            = '0;
        rw.point.degenerate = degen;
        rows.push_back(rw);
    endfunction

    // random load: mostly near-unit normals and modest positions
    function automatic spr_in_t random_load();
        int idx, px, py, pz, nx, ny, nz, sel;
        real rz;
        idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            px = $urandom;
            py = $urandom;
            pz = $urandom;
        end
        else
        begin
            px = $signed($urandom_range(0, 2097151)) - 1048576;
            py = $signed($urandom_range(0, 2097151)) - 1048576;
            pz = $signed($urandom_range(0, 2097151)) - 1048576;
        end
        if ($urandom_range(0, 9) < 2)
        begin
            nx = $urandom;
            ny = $urandom;
            nz = $urandom;
        end
        else
        begin
            nx = $signed($urandom_range(0, 22000)) - 11000;
            ny = $signed($urandom_range(0, 22000)) - 11000;
            rz = $sqrt(268435456.0 - real'(nx * nx) - real'(ny * ny));
            nz = $rtoi(rz);
            if ($urandom_range(0, 1)) nz = -nz;
        end
        return load_item(idx, px, py, pz, nx, ny, nz);
    endfunction

    // random evaluate over written corners, weights mostly summing to one
    function automatic spr_in_t random_eval();
        int a, b, c, w0, w1, w2, sel;
        a   = written_list[$urandom_range(0, written_list.size() - 1)];
        b   = written_list[$urandom_range(0, written_list.size() - 1)];
        c   = written_list[$urandom_range(0, written_list.size() - 1)];
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            w0 = $urandom_range(0, 65536);
            w1 = $urandom_range(0, 65536 - w0);
            w2 = 65536 - w0 - w1;
        end
        else if (sel < 8)
        begin
            w0 = $urandom_range(0, 131071);
            w1 = $urandom_range(0, 131071);
            w2 = $urandom_range(0, 131071);
        end
        else
        begin
            // a corner dropped out
            w0 = $urandom_range(0, 65536);
            w1 = 65536 - w0;
            w2 = 0;
        end
        return eval_item(a, b, c, w0, w1, w2);
    endfunction

    // ---------------------------------------------------------------------
    // driver: changes at the falling edge, accept seen at the rising edge
    // ---------------------------------------------------------------------
    task automatic send_item(input spr_in_t it, input bit typed, input spr_out_t typed_point);
        int gap;
        if (burst_left == 0)
        begin
            // random gap between bursts, sometimes none
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        item  = it;
        start = 1'b1;
        do @(posedge clk); while (busy);
        // item accepted at this edge: update the model state
        if (it.cmd == CMD_LOAD)
        begin
            vx_pos[it.vertex_index][0] = it.load_pos_x;
            vx_pos[it.vertex_index][1] = it.load_pos_y;
            vx_pos[it.vertex_index][2] = it.load_pos_z;
            vx_nrm[it.vertex_index][0] = it.load_nrm_x;
            vx_nrm[it.vertex_index][1] = it.load_nrm_y;
            vx_nrm[it.vertex_index][2] = it.load_nrm_z;
            if (!vx_written[it.vertex_index])
            begin
                vx_written[it.vertex_index] = 1'b1;
                written_list.push_back(it.vertex_index);
            end
        end
        else if (typed)
            pending_points.push_back(typed_point);
        else
            pending_points.push_back(smooth_point(it));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_points();
        start = 1'b0;
        while (pending_points.size() != 0) @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        spr_out_t exp_pt;
        if (rst_n && result_valid)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result strobe with no evaluate item outstanding");
                errors++;
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                check_field("out_pos_x", exp_pt.out_pos_x, result.out_pos_x);
                check_field("out_pos_y", exp_pt.out_pos_y, result.out_pos_y);
                check_field("out_pos_z", exp_pt.out_pos_z, result.out_pos_z);
                check_field("out_nrm_x", exp_pt.out_nrm_x, result.out_nrm_x);
                check_field("out_nrm_y", exp_pt.out_nrm_y, result.out_nrm_y);
                check_field("out_nrm_z", exp_pt.out_nrm_z, result.out_nrm_z);
                check_field("degenerate", exp_pt.degenerate, result.degenerate);
            end
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;

        // directed rows: vertex extremes first, then each special case
        add_row(load_item(0, 0, 0, 0, 0, 0, UNIT), 0, 0);
        add_row(load_item(1, 65536, 0, 0, 0, 0, UNIT), 0, 0);
        add_row(load_item(2, 0, 65536, 0, 0, 0, UNIT), 0, 0);
        add_row(load_item(4095, 8388607, 8388607, 8388607, 32767, 32767, 32767), 0, 0);
        add_row(load_item(4094, -8388608, -8388608, -8388608, -32768, -32768, -32768), 0, 0);
        add_row(load_item(3, 1000, -1000, 500, 0, 0, 0), 0, 0);
        add_row(load_item(5, 0, 0, 0, 0, 0, -UNIT), 0, 0);
        // zero weight sum
        add_row(eval_item(0, 1, 2, 0, 0, 0), 1, 1);
        // zero interpolated normal
        add_row(eval_item(3, 3, 3, 65536, 0, 0), 1, 1);
        // a corner normal opposite to the interpolated one: zero denominator
        add_row(eval_item(0, 5, 1, 65536, 0, 0), 1, 1);
        add_row(eval_item(0, 1, 2, 21845, 21845, 21846), 0, 0);
        // largest weights with extreme vertices: saturation and huge lift
        add_row(eval_item(4095, 4094, 0, 131071, 131071, 131071), 0, 0);
        add_row(eval_item(4095, 4095, 4095, 1, 0, 0), 0, 0);
        add_row(eval_item(1, 2, 0, 131071, 0, 0), 0, 0);
        add_row(eval_item(0, 1, 2, 0, 0, 1), 0, 0);
        add_row(load_item(1, -65536, 32768, -32768, 11585, 0, 11585), 0, 0);
        add_row(eval_item(1, 2, 0, 32768, 16384, 16384), 0, 0);
        add_row(eval_item(4094, 1, 2, 65536, 65536, 0), 0, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i]) send_item(rows[i].stim, rows[i].typed, rows[i].point);

        // hold off until every outstanding point has come back
        drain_points();

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 62)
                send_item(random_load(), 0, '0);
            else
                send_item(random_eval(), 0, '0);
        end

        start = 1'b0;
        drain_points();
        // loads cause no result; let the last one settle
        waited = 0;
        while (waited < 20)
        begin
            @(negedge clk);
            waited++;
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
